[hw/rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and defaults for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Fixed payload widths
    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 13;
    localparam int COUNT_W  = 14;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_BLOCKS = 8192;
    localparam int DEF_WORD_BITS  = 64;

    localparam logic [COUNT_W-1:0] RESET_BLOCK_COUNT = 14'd5192;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_COUNT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    // What a word scan is doing
    typedef enum logic [1:0] {
        MODE_ALLOC,
        MODE_FREE,
        MODE_MARK,
        MODE_RECOUNT
    } scan_mode_t;

    // Controller -> datapath
    typedef struct packed {
        logic       accept;     // latch index, reset result
        logic       start;      // rewind scan pointers
        logic       zero_used;  // clear used counter
        logic       issue;      // read next map word
        logic       commit;     // act on current beat (alloc/free/mark)
        logic       accum;      // add current beat to used counter
        logic       clear_map;  // drop every map row
        logic       set_range;  // index out of range result
        logic       load_out;   // move result into output register
        scan_mode_t mode;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic beat;      // read data of the scan is valid
        logic hit;       // beat holds the wanted block
        logic last;      // beat is the last live word
        logic idx_oor;   // incoming index at or beyond block count
        logic out_busy;  // output word held by a stall
    } dp_stat_t;

endpackage

[hw/rtl/block_bitmap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// First-fit block allocator over a used/free bitmap held in on-chip memory.
//
//   channel | signals                              | dir | word contents
//   --------+--------------------------------------+-----+--------------------------------
//   in      | in_valid, in_stall                   | in  | func, block_index
//   out     | out_valid, out_stall                 | out | status, allocated_index,
//           |                                      |     | free_count
//   config  | block_count_we, block_count          | in  | block count (no read-back)
//
// Scans: allocate, free and mark walk the map one memory word per cycle from
//   word 0, bounded by the single read port, up to the word that holds the
//   block or the last live word. Count, clear, unused codes and out-of-range
//   indexes skip the scan and go straight to the result.
// A block_count write restarts a used-counter recount over the live map
//   words (at least one), count saturated at MAX_BLOCKS; in_stall stays high
//   meanwhile.
// Reset: map rows carry valid flags cleared at once, so no clearing pass.
//   Clear-all drops the flags all together.
// Stalls: one request at a time; the next one is taken while a result waits
//   in the output register, and it finishes once that register is free.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit
#(
    parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
    parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    // request word
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bba_pkg::FUNC_W-1:0]   func,
    input  logic [bba_pkg::INDEX_W-1:0]  block_index,

    // result word
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bba_pkg::STATUS_W-1:0] status,
    output logic [bba_pkg::INDEX_W-1:0]  allocated_index,
    output logic [bba_pkg::COUNT_W-1:0]  free_count,

    // block count register
    input  logic                         block_count_we,
    input  logic [bba_pkg::COUNT_W-1:0]  block_count
);

    bba_pkg::ctrl_cmd_t cmd;
    bba_pkg::dp_stat_t  stat;

    // shadow of the block count for the bound check
    logic [bba_pkg::COUNT_W-1:0] block_count_q;

    // Sequencer: decode, scan control, result hand-off
    bba_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .func           (func),
        .block_count_we (block_count_we),
        .stat           (stat),
        .cmd            (cmd),
        .in_stall       (in_stall)
    );

    // Bitmap memory, bit search, counters, output register
    bba_datapath
    #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .block_count_we  (block_count_we),
        .block_count     (block_count),
        .block_index     (block_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .allocated_index (allocated_index),
        .free_count      (free_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_q <= bba_pkg::RESET_BLOCK_COUNT;
        end
        else if (block_count_we)
        begin
            block_count_q <= block_count;
        end
    end

    // one request in flight: taking a word closes the input next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while another is in flight");

    // free count never exceeds the configured count
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (free_count <= block_count_q))
        else $error("free count above block count");

    // failed allocation means a full map and no index
    a_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == bba_pkg::ST_NO_FREE)) |->
        ((allocated_index == '0) && (free_count == '0)))
        else $error("no-free result with free blocks or an index");

    // result is only loaded into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid && out_stall))
        else $error("output word overwritten under stall");

endmodule

[hw/rtl/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: decodes a request, runs the map scan, hands off result.
// ----------------------------------------------------------------------------
module bba_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [bba_pkg::FUNC_W-1:0] func,
    input  logic                      block_count_we,
    input  bba_pkg::dp_stat_t         stat,
    output bba_pkg::ctrl_cmd_t        cmd,
    output logic                      in_stall
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_RESULT = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    bba_pkg::scan_mode_t mode_reg;
    bba_pkg::scan_mode_t mode_next;

    assign in_stall = (state_reg != S_IDLE) || block_count_we;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        cmd           = '0;
        cmd.mode      = mode_reg;

        if (block_count_we)
        begin
            // new count: rebuild used counter from the map
            cmd.start     = 1'b1;
            cmd.zero_used = 1'b1;
            mode_next     = bba_pkg::MODE_RECOUNT;
            state_next    = S_SCAN;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.accept = 1'b1;
                        case (func)
                            bba_pkg::FUNC_ALLOC:
                            begin
                                cmd.start  = 1'b1;
                                mode_next  = bba_pkg::MODE_ALLOC;
                                state_next = S_SCAN;
                            end
                            bba_pkg::FUNC_FREE,
                            bba_pkg::FUNC_MARK:
                            begin
                                if (stat.idx_oor)
                                begin
                                    cmd.set_range = 1'b1;
                                    state_next    = S_RESULT;
                                end
                                else
                                begin
                                    cmd.start  = 1'b1;
                                    mode_next  = (func == bba_pkg::FUNC_FREE) ?
                                                 bba_pkg::MODE_FREE : bba_pkg::MODE_MARK;
                                    state_next = S_SCAN;
                                end
                            end
                            bba_pkg::FUNC_CLEAR:
                            begin
                                cmd.clear_map = 1'b1;
                                state_next    = S_RESULT;
                            end
                            default:
                            begin
                                state_next = S_RESULT;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    cmd.issue = 1'b1;
                    if (stat.beat)
                    begin
                        if (mode_reg == bba_pkg::MODE_RECOUNT)
                        begin
                            cmd.accum = 1'b1;
                            if (stat.last)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else if (stat.hit || stat.last)
                        begin
                            cmd.commit = 1'b1;
                            state_next = S_RESULT;
                        end
                    end
                end
                S_RESULT:
                begin
                    if (!stat.out_busy)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= bba_pkg::MODE_ALLOC;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

[hw/rtl/bba_datapath.sv]
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap memory with row valid flags, scan pointers, bit search, used
// counter, result and output registers.
// ----------------------------------------------------------------------------
module bba_datapath
#(
    parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
    parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bba_pkg::ctrl_cmd_t           cmd,
    output bba_pkg::dp_stat_t            stat,
    input  logic                         block_count_we,
    input  logic [bba_pkg::COUNT_W-1:0]  block_count,
    input  logic [bba_pkg::INDEX_W-1:0]  block_index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bba_pkg::STATUS_W-1:0] status,
    output logic [bba_pkg::INDEX_W-1:0]  allocated_index,
    output logic [bba_pkg::COUNT_W-1:0]  free_count
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW        = $clog2(MAX_BLOCKS + 1);
    localparam int BASE_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int POP_W     = $clog2(WORD_BITS + 1);
    localparam int NGRP      = (WORD_BITS + 7) / 8;

    // ones in a word, bytes first then byte sums
    function automatic logic [POP_W-1:0] pop_word(input logic [WORD_BITS-1:0] w);
        logic [POP_W-1:0] total;
        logic [3:0]       grp;
        total = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            grp = '0;
            for (int b = 0; b < 8; b++)
            begin
                if (g * 8 + b < WORD_BITS)
                begin
                    grp = grp + 4'(w[g * 8 + b]);
                end
            end
            total = total + POP_W'(grp);
        end
        return total;
    endfunction

    // position of the single set bit
    function automatic logic [BIT_W-1:0] enc_onehot(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (w[i])
            begin
                pos = pos | BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // Map storage
    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] row_vld_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 rd_vld_reg;

    // Scan pointers
    logic [AW-1:0]     addr_reg;
    logic [BASE_W-1:0] base_reg;
    logic              dat_vld_reg;
    logic [AW-1:0]     dat_addr_reg;
    logic [BASE_W-1:0] dat_base_reg;

    logic [bba_pkg::COUNT_W-1:0] block_count_reg;
    logic [bba_pkg::INDEX_W-1:0] idx_reg;
    logic [CW-1:0]               used_reg;

    logic [bba_pkg::STATUS_W-1:0] status_res_reg;
    logic [bba_pkg::INDEX_W-1:0]  alloc_res_reg;

    logic                         out_valid_reg;
    logic [bba_pkg::STATUS_W-1:0] status_reg;
    logic [bba_pkg::INDEX_W-1:0]  allocated_index_reg;
    logic [bba_pkg::COUNT_W-1:0]  free_count_reg;

    // Beat logic
    logic [CW-1:0]        n_live;
    logic [BASE_W-1:0]    n_ext;
    logic [BASE_W-1:0]    rem;
    logic [BASE_W-1:0]    diff;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] live_mask;
    logic [WORD_BITS-1:0] free_vec;
    logic [WORD_BITS-1:0] first_free;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] new_word;
    logic [BIT_W-1:0]     off;
    logic                 cur_bit;
    logic                 hit;
    logic                 last;
    logic                 wr_en;

    assign n_live = (32'(block_count_reg) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                               : CW'(block_count_reg);
    assign n_ext  = BASE_W'(n_live);
    assign word   = rd_vld_reg ? rd_word_reg : '0;
    assign rem    = (n_ext > dat_base_reg) ? (n_ext - dat_base_reg) : '0;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            live_mask[i] = (BASE_W'(i) < rem);
        end
    end

    // lowest free live bit: isolate via two's complement
    assign free_vec   = ~word & live_mask;
    assign first_free = free_vec & (~free_vec + WORD_BITS'(1));

    assign diff     = BASE_W'(idx_reg) - dat_base_reg;
    assign off      = diff[BIT_W-1:0];
    assign bit_mask = WORD_BITS'(1) << off;
    assign cur_bit  = |(word & bit_mask);

    assign last = (dat_base_reg + BASE_W'(WORD_BITS)) >= n_ext;

    always_comb
    begin
        case (cmd.mode)
            bba_pkg::MODE_ALLOC:
            begin
                hit      = |free_vec;
                new_word = word | first_free;
            end
            bba_pkg::MODE_FREE:
            begin
                hit      = diff < BASE_W'(WORD_BITS);
                new_word = word & ~bit_mask;
            end
            bba_pkg::MODE_MARK:
            begin
                hit      = diff < BASE_W'(WORD_BITS);
                new_word = word | bit_mask;
            end
            default:
            begin
                hit      = 1'b0;
                new_word = word;
            end
        endcase
    end

    assign wr_en = cmd.commit && hit;

    assign stat.beat     = dat_vld_reg;
    assign stat.hit      = hit;
    assign stat.last     = last;
    assign stat.idx_oor  = 32'(block_index) >= 32'(n_live);
    assign stat.out_busy = out_valid_reg && out_stall;

    // Memory array: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[dat_addr_reg] <= new_word;
        end
        if (cmd.issue)
        begin
            rd_word_reg <= mem[addr_reg];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg <= block_index;
        end
        if (cmd.issue)
        begin
            dat_addr_reg <= addr_reg;
            dat_base_reg <= base_reg;
        end
        if (cmd.load_out)
        begin
            status_reg          <= status_res_reg;
            allocated_index_reg <= alloc_res_reg;
            free_count_reg      <= (used_reg <= n_live) ?
                                   bba_pkg::COUNT_W'(n_live - used_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg     <= '0;
            rd_vld_reg      <= 1'b0;
            addr_reg        <= '0;
            base_reg        <= '0;
            dat_vld_reg     <= 1'b0;
            block_count_reg <= bba_pkg::RESET_BLOCK_COUNT;
            used_reg        <= '0;
            status_res_reg  <= bba_pkg::ST_OK;
            alloc_res_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (block_count_we)
            begin
                block_count_reg <= block_count;
            end

            // row flags: unwritten or cleared rows read as all free
            if (cmd.clear_map)
            begin
                row_vld_reg <= '0;
            end
            else if (wr_en)
            begin
                row_vld_reg[dat_addr_reg] <= 1'b1;
            end

            if (cmd.start)
            begin
                addr_reg    <= '0;
                base_reg    <= '0;
                dat_vld_reg <= 1'b0;
            end
            else if (cmd.issue)
            begin
                rd_vld_reg  <= row_vld_reg[addr_reg];
                dat_vld_reg <= 1'b1;
                if (32'(addr_reg) < MAP_WORDS - 1)
                begin
                    addr_reg <= addr_reg + AW'(1);
                    base_reg <= base_reg + BASE_W'(WORD_BITS);
                end
            end

            // used counter
            if (cmd.zero_used || cmd.clear_map)
            begin
                used_reg <= '0;
            end
            else if (cmd.accum)
            begin
                used_reg <= used_reg + CW'(pop_word(word & live_mask));
            end
            else if (wr_en)
            begin
                case (cmd.mode)
                    bba_pkg::MODE_ALLOC:
                    begin
                        used_reg <= used_reg + CW'(1);
                    end
                    bba_pkg::MODE_FREE:
                    begin
                        if (cur_bit)
                        begin
                            used_reg <= used_reg - CW'(1);
                        end
                    end
                    bba_pkg::MODE_MARK:
                    begin
                        if (!cur_bit)
                        begin
                            used_reg <= used_reg + CW'(1);
                        end
                    end
                    default:
                    begin
                        used_reg <= used_reg;
                    end
                endcase
            end

            // result of the request in flight; range error comes with accept
            if (cmd.accept)
            begin
                status_res_reg <= cmd.set_range ? bba_pkg::ST_RANGE : bba_pkg::ST_OK;
                alloc_res_reg  <= '0;
            end
            else if (cmd.commit && (cmd.mode == bba_pkg::MODE_ALLOC))
            begin
                if (hit)
                begin
                    alloc_res_reg <= bba_pkg::INDEX_W'(dat_base_reg +
                                                       BASE_W'(enc_onehot(first_free)));
                end
                else
                begin
                    status_res_reg <= bba_pkg::ST_NO_FREE;
                end
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign allocated_index = allocated_index_reg;
    assign free_count      = free_count_reg;

endmodule
